@@ rtl/sgdm_pkg.sv @@
`default_nettype none
package sgdm_pkg;

  // Register stages inside one floating-point multiplier and one adder.
  localparam int MUL_LAT = 3;
  localparam int ADD_LAT = 3;
  // Clock edges from the edge that accepts a word to the edge that takes its result:
  // one input stage, four multiply-then-add steps, one output stage.
  localparam int PIPE_LAT = 2 + 4 * (MUL_LAT + ADD_LAT);

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [15:0] BF_QNAN = 16'h7FC0;

  localparam logic [1:0] FMT_FP32  = 2'd0;
  localparam logic [1:0] FMT_SPLIT = 2'd1;
  localparam logic [1:0] FMT_MIXED = 2'd2;

  localparam logic [2:0] REG_MOMENTUM = 3'd0;
  localparam logic [2:0] REG_LR       = 3'd1;
  localparam logic [2:0] REG_DECAY    = 3'd2;
  localparam logic [2:0] REG_DAMP     = 3'd3;
  localparam logic [2:0] REG_NESTEROV = 3'd4;
  localparam logic [2:0] REG_READY    = 3'd5;
  localparam logic [2:0] REG_FORMAT   = 3'd6;

  // Special-value class of a result, carried between arithmetic stages.
  typedef struct packed {
    logic nan;
    logic inf;
    logic inf_sign;
    logic zero;
    logic zero_sign;
  } fp_cls_t;

endpackage
`default_nettype wire

@@ rtl/sgdm_fmul.sv @@
`default_nettype none
module sgdm_fmul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import sgdm_pkg::*;

  logic [7:0]         ea, eb, ea_eff, eb_eff;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  fp_cls_t            cls1_nxt, cls1_r, cls2_r;
  logic               sign1_r, sign2_r;
  logic [47:0]        prod1_r, prod2_r;
  logic signed [10:0] exp1_r;
  logic [5:0]         lz;
  logic signed [10:0] er2_nxt, er2_r, sh2_nxt, sh2_r;
  logic [47:0]        n;
  logic               stx;
  logic [6:0]         rsh;
  logic [30:0]        packed_v;
  logic [7:0]         expf;
  logic               rnd;
  logic [31:0]        y_nxt, y_r;

  // Stage 1: classify operands and form the full significand product.
  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    ea_eff = (ea == 8'd0) ? 8'd1 : ea;
    eb_eff = (eb == 8'd0) ? 8'd1 : eb;
    a_nan = (&ea) && (|a[22:0]);
    b_nan = (&eb) && (|b[22:0]);
    a_inf = (&ea) && !(|a[22:0]);
    b_inf = (&eb) && !(|b[22:0]);
    a_zero = !(|a[30:0]);
    b_zero = !(|b[30:0]);
    cls1_nxt.nan = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    cls1_nxt.inf = a_inf || b_inf;
    cls1_nxt.inf_sign = a[31] ^ b[31];
    cls1_nxt.zero = a_zero || b_zero;
    cls1_nxt.zero_sign = a[31] ^ b[31];
  end

  always_ff @(posedge clk) begin
    prod1_r <= {|ea, a[22:0]} * {|eb, b[22:0]};
    exp1_r <= $signed({3'b0, ea_eff}) + $signed({3'b0, eb_eff}) - 11'sd127;
    cls1_r <= cls1_nxt;
    sign1_r <= a[31] ^ b[31];
  end

  // Stage 2: leading-zero count and normalizing shift amount.
  always_comb begin
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (prod1_r[i]) lz = 6'(47 - i);
    end
    er2_nxt = exp1_r + 11'sd1 - $signed({5'b0, lz});
    sh2_nxt = (er2_nxt >= 11'sd1) ? $signed({5'b0, lz}) : exp1_r;
  end

  always_ff @(posedge clk) begin
    prod2_r <= prod1_r;
    er2_r <= er2_nxt;
    sh2_r <= sh2_nxt;
    cls2_r <= cls1_r;
    sign2_r <= sign1_r;
  end

  // Stage 3: shift, round to nearest even, pack.
  always_comb begin
    rsh = 7'(-sh2_r);
    stx = 1'b0;
    if (sh2_r >= 11'sd0) begin
      n = prod2_r << sh2_r[5:0];
    end else if (rsh >= 7'd48) begin
      n = '0;
      stx = |prod2_r;
    end else begin
      n = prod2_r >> rsh;
      stx = |(prod2_r & ~({48{1'b1}} << rsh));
    end
    expf = (er2_r >= 11'sd1) ? er2_r[7:0] : 8'd0;
    rnd = n[23] && ((|n[22:0]) || stx || n[24]);
    packed_v = {expf, n[46:24]} + {30'd0, rnd};
    if (cls2_r.nan) begin
      y_nxt = FP_QNAN;
    end else if (cls2_r.inf) begin
      y_nxt = {cls2_r.inf_sign, 8'hFF, 23'd0};
    end else if (cls2_r.zero) begin
      y_nxt = {cls2_r.zero_sign, 31'd0};
    end else if (er2_r >= 11'sd255) begin
      y_nxt = {sign2_r, 8'hFF, 23'd0};
    end else begin
      y_nxt = {sign2_r, packed_v};
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

  assign y = y_r;

endmodule
`default_nettype wire

@@ rtl/sgdm_fadd.sv @@
`default_nettype none
module sgdm_fadd (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import sgdm_pkg::*;

  logic [7:0]        ea, eb, e_big, e_sml, d;
  logic              a_nan, b_nan, a_inf, b_inf, a_big;
  logic [31:0]       big, sml;
  logic [26:0]       m_big, m_sml, sh_sml, sml_al;
  logic              stk;
  fp_cls_t           cls1_nxt, cls1_r, cls2_r;
  logic [26:0]       big1_r, sml1_r;
  logic [7:0]        exp1_r;
  logic              sign1_r, sub1_r, sign2_r;
  logic [27:0]       sum, sum2_r;
  logic [4:0]        lz;
  logic signed [9:0] er2_nxt, er2_r;
  logic [4:0]        sh2_nxt, sh2_r;
  logic [27:0]       n;
  logic [7:0]        expf;
  logic              rnd;
  logic [30:0]       packed_v;
  logic [31:0]       y_nxt, y_r;

  // Stage 1: classify, order by magnitude, align the smaller operand.
  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    a_nan = (&ea) && (|a[22:0]);
    b_nan = (&eb) && (|b[22:0]);
    a_inf = (&ea) && !(|a[22:0]);
    b_inf = (&eb) && !(|b[22:0]);
    a_big = a[30:0] >= b[30:0];
    big = a_big ? a : b;
    sml = a_big ? b : a;
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d = e_big - e_sml;
    m_big = {|big[30:23], big[22:0], 3'b000};
    m_sml = {|sml[30:23], sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      sh_sml = '0;
      stk = |m_sml;
    end else begin
      sh_sml = m_sml >> d[4:0];
      stk = |(m_sml & ~({27{1'b1}} << d[4:0]));
    end
    sml_al = {sh_sml[26:1], sh_sml[0] | stk};
    cls1_nxt.nan = a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31]));
    cls1_nxt.inf = a_inf || b_inf;
    cls1_nxt.inf_sign = a_inf ? a[31] : b[31];
    cls1_nxt.zero = 1'b0;
    cls1_nxt.zero_sign = a[31] && b[31];
  end

  always_ff @(posedge clk) begin
    big1_r <= m_big;
    sml1_r <= sml_al;
    exp1_r <= e_big;
    sign1_r <= big[31];
    sub1_r <= a[31] ^ b[31];
    cls1_r <= cls1_nxt;
  end

  // Stage 2: add or subtract, count leading zeros.
  always_comb begin
    sum = sub1_r ? ({1'b0, big1_r} - {1'b0, sml1_r}) : ({1'b0, big1_r} + {1'b0, sml1_r});
    lz = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (sum[i]) lz = 5'(27 - i);
    end
    er2_nxt = $signed({2'b0, exp1_r}) + 10'sd1 - $signed({5'b0, lz});
    sh2_nxt = (er2_nxt >= 10'sd1) ? lz : exp1_r[4:0];
  end

  always_ff @(posedge clk) begin
    sum2_r <= sum;
    er2_r <= er2_nxt;
    sh2_r <= sh2_nxt;
    sign2_r <= sign1_r;
    cls2_r <= '{nan: cls1_r.nan, inf: cls1_r.inf, inf_sign: cls1_r.inf_sign,
                zero: (sum == 28'd0), zero_sign: cls1_r.zero_sign};
  end

  // Stage 3: normalize, round to nearest even, pack.
  always_comb begin
    n = sum2_r << sh2_r;
    expf = (er2_r >= 10'sd1) ? er2_r[7:0] : 8'd0;
    rnd = n[3] && ((|n[2:0]) || n[4]);
    packed_v = {expf, n[26:4]} + {30'd0, rnd};
    if (cls2_r.nan) begin
      y_nxt = FP_QNAN;
    end else if (cls2_r.inf) begin
      y_nxt = {cls2_r.inf_sign, 8'hFF, 23'd0};
    end else if (cls2_r.zero) begin
      y_nxt = {cls2_r.zero_sign, 31'd0};
    end else if (er2_r >= 10'sd255) begin
      y_nxt = {sign2_r, 8'hFF, 23'd0};
    end else begin
      y_nxt = {sign2_r, packed_v};
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

  assign y = y_r;

endmodule
`default_nettype wire

@@ rtl/sgd_momentum_update.sv @@
`default_nettype none
// Channel   | Handshake          | Word
// ----------+--------------------+--------------------------------------------------
// input     | start, busy        | in_param_word, in_param_low_half, in_grad_word,
//           |                    | in_momentum_in
// result    | out_valid          | out_param_out, out_param_aux_out, out_momentum_out,
//           |                    | out_momentum_written
// config    | psel, penable, ... | paddr, pwdata, prdata
//
// A word is accepted on every cycle that start is high; busy never rises.
// Each result's out_valid rises once its word has passed one input stage, four dependent
// multiply-then-add steps of six stages each and one output stage.
// rst_n is synchronous and clears the valid bits and the configuration registers.
// Nothing ever stalls: the receiver takes every result in the cycle it shows.
// Configuration is to be written by the user only while no word is in flight; the block itself does not enforce this.
module sgd_momentum_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_param_word,
  input  logic [15:0] in_param_low_half,
  input  logic [31:0] in_grad_word,
  input  logic [31:0] in_momentum_in,
  output logic        out_valid,
  output logic [31:0] out_param_out,
  output logic [15:0] out_param_aux_out,
  output logic [31:0] out_momentum_out,
  output logic        out_momentum_written,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sgdm_pkg::*;

  // Delay lengths follow the unit latencies so the operands of every step line up.
  localparam int STEP   = MUL_LAT + ADD_LAT;
  localparam int VLD_D  = 4 * STEP;
  localparam int P_D    = 4 * MUL_LAT + 3 * ADD_LAT;
  localparam int GIN_D  = MUL_LAT;
  localparam int MWM_D  = STEP;
  localparam int MW_D   = 4 * STEP;

  logic [31:0] mom_factor_r, lr_r, decay_r, damp_r;
  logic        nesterov_r, mom_ready_r;
  logic [1:0]  format_r;
  logic        cfg_wr;
  logic        mom_on;
  logic [31:0] keep;

  // Configuration registers.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mom_factor_r <= '0;
      lr_r <= '0;
      decay_r <= '0;
      damp_r <= '0;
      nesterov_r <= 1'b0;
      mom_ready_r <= 1'b0;
      format_r <= FMT_FP32;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MOMENTUM: mom_factor_r <= pwdata;
        REG_LR:       lr_r <= pwdata;
        REG_DECAY:    decay_r <= pwdata;
        REG_DAMP:     damp_r <= pwdata;
        REG_NESTEROV: nesterov_r <= pwdata[0];
        REG_READY:    mom_ready_r <= pwdata[0];
        REG_FORMAT:   format_r <= pwdata[1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MOMENTUM: prdata = mom_factor_r;
      REG_LR:       prdata = lr_r;
      REG_DECAY:    prdata = decay_r;
      REG_DAMP:     prdata = damp_r;
      REG_NESTEROV: prdata = {31'd0, nesterov_r};
      REG_READY:    prdata = {31'd0, mom_ready_r};
      REG_FORMAT:   prdata = {30'd0, format_r};
      default:      prdata = '0;
    endcase
  end

  // Either zero disables momentum; a NaN factor counts as nonzero.
  assign mom_on = |mom_factor_r[30:0];

  // The gradient scale (1 - dampening) is kept up to date from the register.
  sgdm_fadd u_keep (.clk(clk), .a(FP_ONE), .b({~damp_r[31], damp_r[30:0]}), .y(keep));

  // Input stage: unpack the formats into binary32 operands.
  logic        v0_r;
  logic [31:0] p0_r, g0_r, mw0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= (format_r == FMT_SPLIT) ? {in_param_word[15:0], in_param_low_half} : in_param_word;
    g0_r <= (format_r == FMT_SPLIT || format_r == FMT_MIXED) ?
            {in_grad_word[15:0], 16'd0} : in_grad_word;
    mw0_r <= in_momentum_in;
  end

  // Delay lines that carry operands alongside the arithmetic units.
  logic        vld_d_r [VLD_D];
  logic [31:0] p_d_r   [P_D];
  logic [31:0] gin_d_r [GIN_D];
  logic [31:0] mwm_d_r [MWM_D];
  logic [31:0] g_d_r   [2 * STEP];
  logic [31:0] m_d_r   [2 * STEP];
  logic [31:0] mw_d_r  [MW_D];

  logic [31:0] decay_prod, mwm, g_new, gk, m_full, m_sel, mm, g_look, g2, step_prod, p_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VLD_D; i++) vld_d_r[i] <= 1'b0;
    end else begin
      vld_d_r[0] <= v0_r;
      for (int i = 1; i < VLD_D; i++) vld_d_r[i] <= vld_d_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    p_d_r[0] <= p0_r;
    for (int i = 1; i < P_D; i++) p_d_r[i] <= p_d_r[i-1];
    gin_d_r[0] <= g0_r;
    for (int i = 1; i < GIN_D; i++) gin_d_r[i] <= gin_d_r[i-1];
    mwm_d_r[0] <= mwm;
    for (int i = 1; i < MWM_D; i++) mwm_d_r[i] <= mwm_d_r[i-1];
    g_d_r[0] <= g_new;
    for (int i = 1; i < 2 * STEP; i++) g_d_r[i] <= g_d_r[i-1];
    m_d_r[0] <= m_sel;
    for (int i = 1; i < 2 * STEP; i++) m_d_r[i] <= m_d_r[i-1];
    mw_d_r[0] <= mw0_r;
    for (int i = 1; i < MW_D; i++) mw_d_r[i] <= mw_d_r[i-1];
  end

  // Step one: g = grad + param * decay; the momentum product runs alongside.
  sgdm_fmul u_mul_decay (.clk(clk), .a(p0_r), .b(decay_r), .y(decay_prod));
  sgdm_fmul u_mul_mw (.clk(clk), .a(mw0_r), .b(mom_factor_r), .y(mwm));
  sgdm_fadd u_add_g (.clk(clk), .a(gin_d_r[GIN_D-1]), .b(decay_prod), .y(g_new));

  // Step two: m = m_in * momentum + g * (1 - dampening), or g while the ready register is clear.
  sgdm_fmul u_mul_keep (.clk(clk), .a(g_new), .b(keep), .y(gk));
  sgdm_fadd u_add_m (.clk(clk), .a(mwm_d_r[MWM_D-1]), .b(gk), .y(m_full));
  assign m_sel = mom_ready_r ? m_full : g_d_r[STEP-1];

  // Step three: Nesterov look-ahead g + m * momentum. The gradient tap is delayed to line up
  // with the product of m and the momentum.
  sgdm_fmul u_mul_look (.clk(clk), .a(m_sel), .b(mom_factor_r), .y(mm));
  sgdm_fadd u_add_look (.clk(clk), .a(g_d_r[STEP+MUL_LAT-1]), .b(mm), .y(g_look));

  always_comb begin
    if (!mom_on) begin
      g2 = g_d_r[2*STEP-1];
    end else if (nesterov_r) begin
      g2 = g_look;
    end else begin
      g2 = m_d_r[STEP-1];
    end
  end

  // Step four: param - g * lr, a subtraction as an add of the negated product.
  sgdm_fmul u_mul_lr (.clk(clk), .a(g2), .b(lr_r), .y(step_prod));
  sgdm_fadd u_add_p (.clk(clk), .a(p_d_r[P_D-1]), .b({~step_prod[31], step_prod[30:0]}),
                     .y(p_new));

  // Output stage: format the result word.
  logic [31:0] bf_sum;
  logic [15:0] bf_copy;
  logic [31:0] param_nxt, mom_nxt;
  logic [15:0] aux_nxt;

  always_comb begin
    bf_sum = p_new + 32'h0000_7FFF + {31'd0, p_new[16]};
    bf_copy = ((&p_new[30:23]) && (|p_new[22:0])) ? BF_QNAN : bf_sum[31:16];
    case (format_r)
      FMT_SPLIT: begin
        param_nxt = {16'd0, p_new[31:16]};
        aux_nxt = p_new[15:0];
      end
      FMT_MIXED: begin
        param_nxt = p_new;
        aux_nxt = bf_copy;
      end
      default: begin
        param_nxt = p_new;
        aux_nxt = 16'd0;
      end
    endcase
    mom_nxt = mom_on ? m_d_r[2*STEP-1] : mw_d_r[MW_D-1];
  end

  logic        out_valid_r;
  logic [31:0] param_out_r, mom_out_r;
  logic [15:0] aux_out_r;
  logic        mom_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_d_r[VLD_D-1];
    end
  end

  always_ff @(posedge clk) begin
    param_out_r <= param_nxt;
    aux_out_r <= aux_nxt;
    mom_out_r <= mom_nxt;
    mom_wr_r <= mom_on;
  end

  assign out_valid = out_valid_r;
  assign out_param_out = param_out_r;
  assign out_param_aux_out = aux_out_r;
  assign out_momentum_out = mom_out_r;
  assign out_momentum_written = mom_wr_r;

endmodule
`default_nettype wire

@@ rtl/sgdm_checker.sv @@
`default_nettype none
module sgdm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] in_momentum_in,
  input wire logic        out_valid,
  input wire logic [31:0] out_momentum_out,
  input wire logic        out_momentum_written,
  input wire logic        pready
);
  import sgdm_pkg::*;

  // The block never holds off either side.
  a_never_blocks: assert property (@(posedge clk) disable iff (!rst_n) !busy && pready)
    else $error("busy or pready left the always-open state");

  // Every accepted word yields its result once it has passed through the pipeline.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted word produced no result");

  // No result appears without a word accepted as far back as the pipeline is deep.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching accepted word");

  // With momentum disabled the stored momentum passes through untouched.
  a_mom_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_momentum_written) |->
      (out_momentum_out == $past(in_momentum_in, PIPE_LAT)))
    else $error("momentum changed while the momentum path was off");

endmodule

bind sgd_momentum_update sgdm_checker u_sgdm_checker (.*);
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Self-checking bench for the element-wise SGD momentum update.
// A predictor keeps its own copy of the seven control registers and recomputes each
// update in binary32. Every multiply, add and subtract is rounded to nearest even on its
// own. Each product or sum of two binary32 values is formed in double precision and then
// rounded once to binary32. For these operand widths the double rounding cannot change
// the result. Words are fed through a queue by a clocked driver. A clocked monitor
// compares each result word with the oldest pending prediction.
module tb_top;
  import sgdm_pkg::*;

  typedef struct {
    logic [31:0] param_word;
    logic [15:0] param_low_half;
    logic [31:0] grad_word;
    logic [31:0] momentum_in;
  } elem_t;

  typedef struct {
    logic [31:0] param_out;
    logic [15:0] param_aux_out;
    logic [31:0] momentum_out;
    logic        momentum_written;
  } upd_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_param_word;
  logic [15:0] in_param_low_half;
  logic [31:0] in_grad_word;
  logic [31:0] in_momentum_in;
  logic        out_valid;
  logic [31:0] out_param_out;
  logic [15:0] out_param_aux_out;
  logic [31:0] out_momentum_out;
  logic        out_momentum_written;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the control registers, updated when a write completes.
  logic [31:0] sh_momentum;
  logic [31:0] sh_lr;
  logic [31:0] sh_decay;
  logic [31:0] sh_damp;
  logic        sh_nesterov;
  logic        sh_ready;
  logic [1:0]  sh_format;

  elem_t pending_elems[$];
  upd_t  expected_updates[$];
  int    sender_idle_pct;
  int    mismatches;

  sgd_momentum_update i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_param_word        (in_param_word),
    .in_param_low_half    (in_param_low_half),
    .in_grad_word         (in_grad_word),
    .in_momentum_in       (in_momentum_in),
    .out_valid            (out_valid),
    .out_param_out        (out_param_out),
    .out_param_aux_out    (out_param_aux_out),
    .out_momentum_out     (out_momentum_out),
    .out_momentum_written (out_momentum_written),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Widen a binary32 pattern to binary64. Subnormals are normalized, and any NaN
  // becomes a quiet NaN, since the sign and payload of a NaN are never observed.
  function automatic logic [63:0] widen(logic [31:0] f);
    logic [23:0] m;
    int          e;
    m = {1'b0, f[22:0]};
    e = -126;
    if (f[30:23] == 8'hFF) begin
      return (f[22:0] != 0) ? 64'h7FF8_0000_0000_0000 : {f[31], 11'h7FF, 52'h0};
    end
    if (f[30:23] == 8'h00) begin
      if (f[22:0] == 0) begin
        return {f[31], 63'h0};
      end
      while (!m[23]) begin
        m = m << 1;
        e = e - 1;
      end
    end else begin
      m = {1'b1, f[22:0]};
      e = int'(f[30:23]) - 127;
    end
    return {f[31], 11'(e + 1023), m[22:0], 29'h0};
  endfunction

  // Round a binary64 pattern to binary32, nearest even. Subnormal results keep every
  // bit that fits, overflow gives infinity, and every NaN comes out as the quiet NaN.
  function automatic logic [31:0] narrow(logic [63:0] d);
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    int          e;
    int          sh;
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? FP_QNAN : {d[63], 8'hFF, 23'h0};
    end
    if (d[62:52] == 11'h000) begin
      return {d[63], 31'h0};
    end
    e   = int'(d[62:52]) - 1023;
    sig = {11'h0, 1'b1, d[51:0]};
    sh  = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 63) begin
      sh = 63;
    end
    kept = sig >> sh;
    rem  = sig & ((64'h1 << sh) - 64'h1);
    half = 64'h1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) begin
      kept = kept + 64'h1;
    end
    if (e < -126) begin
      // A carry into bit 23 lands in the exponent field as the smallest normal.
      return {d[63], kept[30:0]};
    end
    if (kept[24]) begin
      kept = kept >> 1;
      e = e + 1;
    end
    if (e > 127) begin
      return {d[63], 8'hFF, 23'h0};
    end
    return {d[63], 8'(e + 127), kept[22:0]};
  endfunction

  function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
    return narrow($realtobits($bitstoreal(widen(a)) * $bitstoreal(widen(b))));
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
    return narrow($realtobits($bitstoreal(widen(a)) + $bitstoreal(widen(b))));
  endfunction

  function automatic logic [31:0] sp_sub(logic [31:0] a, logic [31:0] b);
    return narrow($realtobits($bitstoreal(widen(a)) - $bitstoreal(widen(b))));
  endfunction

  function automatic logic [15:0] to_bfloat(logic [31:0] b);
    logic [31:0] t;
    if (b[30:23] == 8'hFF && b[22:0] != 0) begin
      return BF_QNAN;
    end
    t = b + 32'h7FFF + {31'h0, b[16]};
    return t[31:16];
  endfunction

  // One optimizer step for one element under the shadow registers.
  function automatic upd_t sgd_step(elem_t w);
    upd_t        r;
    logic [31:0] p;
    logic [31:0] g;
    logic [31:0] m;
    logic [31:0] nxt;
    logic        mom_on;
    mom_on = (sh_momentum[30:0] != 0);
    p = (sh_format == FMT_SPLIT) ? {w.param_word[15:0], w.param_low_half} : w.param_word;
    g = (sh_format == FMT_SPLIT || sh_format == FMT_MIXED) ?
        {w.grad_word[15:0], 16'h0} : w.grad_word;
    g = sp_add(g, sp_mul(p, sh_decay));
    r.momentum_out = w.momentum_in;
    if (mom_on) begin
      if (!sh_ready) begin
        m = g;
      end else begin
        m = sp_add(sp_mul(w.momentum_in, sh_momentum),
                   sp_mul(g, sp_sub(FP_ONE, sh_damp)));
      end
      r.momentum_out = m;
      g = sh_nesterov ? sp_add(g, sp_mul(m, sh_momentum)) : m;
    end
    nxt = sp_sub(p, sp_mul(g, sh_lr));
    r.momentum_written = mom_on;
    case (sh_format)
      FMT_SPLIT: begin
        r.param_out     = {16'h0, nxt[31:16]};
        r.param_aux_out = nxt[15:0];
      end
      FMT_MIXED: begin
        r.param_out     = nxt;
        r.param_aux_out = to_bfloat(nxt);
      end
      default: begin
        r.param_out     = nxt;
        r.param_aux_out = 16'h0;
      end
    endcase
    return r;
  endfunction

  // Random binary32 pattern weighted toward finite values of moderate size, with
  // zeros, infinities, NaNs and subnormals mixed in.
  function automatic logic [31:0] rand_fp();
    logic [31:0] specials [8];
    logic [31:0] r;
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0001};
    r = $urandom;
    case ($urandom_range(9))
      0:       return specials[$urandom_range(7)];
      1:       return r;
      2:       return {r[31], 8'h00, r[22:0]};
      default: return {r[31], 8'($urandom_range(150, 100)), r[22:0]};
    endcase
  endfunction

  task automatic add_elem(logic [31:0] pw, logic [15:0] plo, logic [31:0] gw,
                          logic [31:0] mw);
    elem_t w;
    w.param_word     = pw;
    w.param_low_half = plo;
    w.grad_word      = gw;
    w.momentum_in    = mw;
    pending_elems.push_back(w);
  endtask

  // Random elements. In the half-width formats the live halves of about half the elements
  // carry a sensible bfloat value while the ignored upper bits stay random.
  task automatic add_random_elems(int n);
    logic [31:0] pw;
    logic [31:0] gw;
    repeat (n) begin
      pw = rand_fp();
      gw = rand_fp();
      if (sh_format != FMT_FP32 && $urandom_range(1)) begin
        pw = {16'($urandom), pw[31:16]};
        gw = {16'($urandom), gw[31:16]};
      end
      add_elem(pw, 16'($urandom), gw, rand_fp());
    end
  endtask

  // APB write: setup cycle, then access until pready is seen with penable high.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MOMENTUM: sh_momentum = val;
      REG_LR:       sh_lr       = val;
      REG_DECAY:    sh_decay    = val;
      REG_DAMP:     sh_damp     = val;
      REG_NESTEROV: sh_nesterov = val[0];
      REG_READY:    sh_ready    = val[0];
      REG_FORMAT:   sh_format   = val[1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] mom, logic [31:0] lr, logic [31:0] dec,
                           logic [31:0] damp, logic nest, logic rdy, logic [1:0] fmt);
    reg_write(REG_MOMENTUM, mom);
    reg_write(REG_LR, lr);
    reg_write(REG_DECAY, dec);
    reg_write(REG_DAMP, damp);
    reg_write(REG_NESTEROV, {31'h0, nest});
    reg_write(REG_READY, {31'h0, rdy});
    reg_write(REG_FORMAT, {30'h0, fmt});
  endtask

  // Wait until every queued word has been taken and every result has come back,
  // then let the pipeline run empty before the registers are touched.
  task automatic drain();
    do begin
      @(posedge clk);
    end while (pending_elems.size() != 0 || start || expected_updates.size() != 0);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // Driver. A word is taken at an edge where start is high and busy is low; its
  // prediction is queued at that edge under the registers then in force.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        elem_t taken;
        taken.param_word     = in_param_word;
        taken.param_low_half = in_param_low_half;
        taken.grad_word      = in_grad_word;
        taken.momentum_in    = in_momentum_in;
        expected_updates.push_back(sgd_step(taken));
      end
      if (!start || !busy) begin
        if (pending_elems.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          elem_t w;
          w = pending_elems.pop_front();
          start             <= 1'b1;
          in_param_word     <= w.param_word;
          in_param_low_half <= w.param_low_half;
          in_grad_word      <= w.grad_word;
          in_momentum_in    <= w.momentum_in;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result word lives for one cycle and is compared at the edge
  // that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: param %h aux %h mom %h wr %b",
                   out_param_out, out_param_aux_out, out_momentum_out,
                   out_momentum_written);
        end
      end else begin
        upd_t want;
        want = expected_updates.pop_front();
        if (out_param_out !== want.param_out || out_param_aux_out !== want.param_aux_out ||
            out_momentum_out !== want.momentum_out ||
            out_momentum_written !== want.momentum_written) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: param %h/%h aux %h/%h mom %h/%h wr %b/%b (expected/actual)",
                     want.param_out, out_param_out, want.param_aux_out,
                     out_param_aux_out, want.momentum_out, out_momentum_out,
                     want.momentum_written, out_momentum_written);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL sgd_momentum_update");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_param_word     = '0;
    in_param_low_half = '0;
    in_grad_word      = '0;
    in_momentum_in    = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    sh_momentum       = '0;
    sh_lr             = '0;
    sh_decay          = '0;
    sh_damp           = '0;
    sh_nesterov       = 1'b0;
    sh_ready          = 1'b0;
    sh_format         = FMT_FP32;
    sender_idle_pct   = 0;
    mismatches        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Two words under the reset values: momentum off and a zero learning rate.
    add_elem(32'h3F80_0000, 16'h0, 32'h4000_0000, 32'h1234_5678);
    add_elem(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Directed words: signed zeros, infinities, NaNs, the largest finite value,
    // subnormals, and overflow in the update itself.
    write_all(32'h3F00_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3E80_0000, 1'b1, 1'b1,
              FMT_FP32);
    add_elem(32'h0000_0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    add_elem(32'h8000_0000, 16'hFFFF, 32'h8000_0000, 32'h8000_0000);
    add_elem(32'h7F80_0000, 16'h0, 32'h3F80_0000, 32'h0000_0000);
    add_elem(32'hFF80_0000, 16'h0, 32'h7F80_0000, 32'h3F80_0000);
    add_elem(32'h7FC0_0000, 16'h0, 32'h3F80_0000, 32'h3F80_0000);
    add_elem(32'h3F80_0000, 16'h0, 32'hFFC1_2345, 32'h7F80_0001);
    add_elem(32'h7F7F_FFFF, 16'h0, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    add_elem(32'h0000_0001, 16'h0, 32'h8000_0001, 32'h007F_FFFF);
    add_elem(32'h0080_0000, 16'h0, 32'h8080_0000, 32'h0000_0003);
    add_elem(32'hFF7F_FFFF, 16'h0, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
    add_elem(32'h3F80_0000, 16'h0, 32'hBF80_0000, 32'h4000_0000);
    add_elem(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Random phases, each under its own register setting and one of three idling patterns.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_all(32'h3F66_6666, 32'h3C23_D70A, 32'h38D1_B717, 32'h0, 1'b0, 1'b0,
                     FMT_FP32);
        1: write_all(32'h3F66_6666, 32'h3DCC_CCCD, 32'h3A83_126F, 32'h3DCC_CCCD, 1'b1,
                     1'b1, FMT_SPLIT);
        2: write_all(32'h3F00_0000, 32'h3F80_0000, 32'h0, 32'h3F80_0000, 1'b0, 1'b1,
                     FMT_MIXED);
        // Negative zero switches momentum off; the unused format code acts as fp32.
        3: write_all(32'h8000_0000, 32'h3C23_D70A, 32'h3F00_0000, 32'h3E00_0000, 1'b1,
                     1'b1, 2'd3);
        // All ones everywhere: a NaN momentum still counts as switched on.
        4: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     1'b1, 2'd3);
        5: write_all(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000, 1'b1,
                     1'b0, FMT_MIXED);
        default: write_all(rand_fp(), rand_fp(), rand_fp(), rand_fp(), 1'($urandom),
                           1'($urandom), 2'($urandom_range(2)));
      endcase
      case (ph % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 46;
        default: sender_idle_pct = 30;
      endcase
      add_random_elems(150);
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS sgd_momentum_update");
    end else begin
      $display("FAIL sgd_momentum_update");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/sgdm_pkg.sv
rtl/sgdm_fmul.sv
rtl/sgdm_fadd.sv
rtl/sgd_momentum_update.sv
rtl/sgdm_checker.sv
dv/tb_top.sv
